// File: hw/rtl/cplc_pkg.sv
// ----------------------------------------------------------------------------
// cplc_pkg - shared types and constants of the clamped curve evaluator
// Beat layouts for the item and result channels, source codes, register map.
// ----------------------------------------------------------------------------
package cplc_pkg;

	// table geometry
	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// quotient bits produced by the divider (|quotient| <= |upper - lower| < 2^33)
	localparam int DIV_STEPS  = 33;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	// item modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// result source codes
	localparam logic [2:0] SRC_BASE   = 3'd0;
	localparam logic [2:0] SRC_FIRST  = 3'd1;
	localparam logic [2:0] SRC_LAST   = 3'd2;
	localparam logic [2:0] SRC_INTERP = 3'd3;
	localparam logic [2:0] SRC_ACK    = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_BASE   = 2'd1;
	localparam logic [1:0] CFG_COUNT  = 2'd2;

	typedef struct packed {
		logic               mode;
		logic [3:0]         point_index;
		logic signed [15:0] point_level;
		logic signed [31:0] point_value;
		logic signed [15:0] query_level;
	} item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [2:0]         result_source;
	} result_t;

	// one table entry as held in the point memory
	typedef struct packed {
		logic signed [15:0] level;
		logic signed [31:0] value;
	} point_t;

endpackage

// File: hw/rtl/clamped_piecewise_linear_curve.sv
// ----------------------------------------------------------------------------
// clamped_piecewise_linear_curve - clamped piecewise linear curve evaluator
// Point table in a synchronous RAM, slot scan, multiply and serial divide.
// ----------------------------------------------------------------------------
// Usage
//  Item channel (in_valid / in_stall / in_data): a load beat writes one curve
//  point into its slot and is answered with an ack beat (value 0, source 4);
//  a query beat evaluates the curve at query_level. Every item gives exactly
//  one result beat on the result channel (out_valid / out_stall / out_data).
//  Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//  curve_enabled, base_value and point_count; cfg_ready is always high and
//  writes are meant to land only while the block is idle.
// Sequencing
//  One item is in flight at a time. A load or a base value goes straight to
//  the result; a clamped result comes from the slot scan, an interpolated
//  one from the scan, a multiply state, a 33 step restoring divider and a
//  saturating fix-up state; the scan reads one slot per cycle from the RAM
//  port. The next item can be taken in the cycle in which out_valid rises.
// Reset
//  arst_n clears the control state and the configuration registers; the point table holds
//  no reset value and must be loaded before it is queried.
// Stall
//  The result sits in an output register; one further item is accepted and
//  worked on while it waits, and its result is held until the register frees.
// ----------------------------------------------------------------------------
module clamped_piecewise_linear_curve (
	input  logic             clk,
	input  logic             arst_n,
	// item channel
	input  logic             in_valid,
	output logic             in_stall,
	input  cplc_pkg::item_t  in_data,
	// result channel
	output logic             out_valid,
	input  logic             out_stall,
	output cplc_pkg::result_t out_data,
	// configuration write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_FIX  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;

	// configuration registers
	logic                        enabled_q;
	logic signed [31:0]          base_q;
	logic [cplc_pkg::CNT_W-1:0]  count_q;

	// point memory and its registered read port
	cplc_pkg::point_t            pts_mem [cplc_pkg::MAX_POINTS];
	cplc_pkg::point_t            rd_q;
	logic [cplc_pkg::IDX_W-1:0]  rd_addr;

	// working registers of the current query
	logic signed [15:0]          q_q;
	logic [cplc_pkg::IDX_W-1:0]  cnt_q;
	cplc_pkg::point_t            prev_q;
	logic signed [32:0]          diff_q;
	logic [15:0]                 dq_q;
	logic [15:0]                 den_q;
	logic                        neg_q;
	logic [15:0]                 rem_q;
	logic [32:0]                 qr_q;
	logic [cplc_pkg::STEP_W-1:0] step_q;

	// pending result and the output register
	logic signed [31:0]          res_value_q;
	logic [2:0]                  res_src_q;
	logic                        out_valid_q;
	cplc_pkg::result_t           out_data_q;

	logic                        accept;
	logic                        load_wr;
	logic [cplc_pkg::CNT_W-1:0]  count_eff;
	logic [cplc_pkg::IDX_W-1:0]  last_idx;
	logic                        found;
	logic signed [32:0]          diff_d;
	logic [16:0]                 dq_d;
	logic [16:0]                 den_d;
	logic [32:0]                 diff_mag;
	logic [48:0]                 prod_d;
	logic [16:0]                 trial;
	logic                        trial_ge;
	logic [16:0]                 trial_sub;
	logic signed [34:0]          quo_d;
	logic signed [34:0]          sum_d;
	logic signed [31:0]          sat_d;
	logic                        out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign load_wr   = accept && (in_data.mode == cplc_pkg::MODE_LOAD) &&
	                   ({1'b0, in_data.point_index} < cplc_pkg::CNT_W'(cplc_pkg::MAX_POINTS));

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || !out_stall;

	// counts above the table depth act as a full table
	assign count_eff = (count_q > cplc_pkg::CNT_W'(cplc_pkg::MAX_POINTS)) ?
	                   cplc_pkg::CNT_W'(cplc_pkg::MAX_POINTS) : count_q;
	assign last_idx  = cplc_pkg::IDX_W'(count_eff - 1'b1);

	// the scan reads slot 0 at acceptance, then the next slot each cycle
	assign rd_addr = (state_q == ST_SCAN) ? cplc_pkg::IDX_W'(cnt_q + 1'b1) : '0;

	// scan compare and interpolation operands
	assign found  = (rd_q.level >= q_q);
	assign diff_d = {rd_q.value[31], rd_q.value} - {prev_q.value[31], prev_q.value};
	assign dq_d   = {q_q[15], q_q} - {prev_q.level[15], prev_q.level};
	assign den_d  = {rd_q.level[15], rd_q.level} - {prev_q.level[15], prev_q.level};

	// |upper - lower| * (q - lo), below 2^48
	assign diff_mag = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
	assign prod_d   = {16'b0, diff_mag} * {33'b0, dq_q};

	// one restoring divide step; remainder stays below the divisor
	assign trial     = {rem_q, qr_q[32]};
	assign trial_ge  = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};

	// signed quotient, sum and saturation to 32 bits
	assign quo_d = neg_q ? -$signed({2'b0, qr_q}) : $signed({2'b0, qr_q});
	assign sum_d = {{3{prev_q.value[31]}}, prev_q.value} + quo_d;
	always_comb begin
		if (sum_d[34:31] == 4'b0000 || sum_d[34:31] == 4'b1111) begin
			sat_d = sum_d[31:0];
		end else if (sum_d[34]) begin
			sat_d = 32'sh8000_0000;
		end else begin
			sat_d = 32'sh7fff_ffff;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			base_q    <= '0;
			count_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cplc_pkg::CFG_ENABLE: enabled_q <= cfg_data[0];
				cplc_pkg::CFG_BASE:   base_q    <= cfg_data;
				cplc_pkg::CFG_COUNT:  count_q   <= cfg_data[cplc_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// point memory: one write port, one read port with registered data
	always_ff @(posedge clk) begin
		if (load_wr) begin
			pts_mem[in_data.point_index] <= {in_data.point_level, in_data.point_value};
		end
		rd_q <= pts_mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.mode == cplc_pkg::MODE_QUERY && enabled_q &&
						    count_eff != '0) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (found) begin
						state_q <= (cnt_q == '0 || rd_q.level <= prev_q.level) ?
						           ST_DONE : ST_MUL;
					end else if (cnt_q == last_idx) begin
						state_q <= ST_DONE;
					end
				end
				ST_MUL:  state_q <= ST_DIV;
				ST_DIV:  if (step_q == '0) state_q <= ST_FIX;
				ST_FIX:  state_q <= ST_DONE;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cnt_q <= '0;
				q_q   <= in_data.query_level;
				if (in_data.mode == cplc_pkg::MODE_LOAD) begin
					res_value_q <= '0;
					res_src_q   <= cplc_pkg::SRC_ACK;
				end else begin
					res_value_q <= base_q;
					res_src_q   <= cplc_pkg::SRC_BASE;
				end
			end
			ST_SCAN: begin
				if (found && cnt_q == '0) begin
					res_value_q <= rd_q.value;
					res_src_q   <= cplc_pkg::SRC_FIRST;
				end else if (found) begin
					// a level at or below the previous one falls back to the lower value
					res_value_q <= prev_q.value;
					res_src_q   <= cplc_pkg::SRC_INTERP;
					diff_q      <= diff_d;
					dq_q        <= dq_d[15:0];
					den_q       <= den_d[15:0];
				end else if (cnt_q == last_idx) begin
					res_value_q <= rd_q.value;
					res_src_q   <= cplc_pkg::SRC_LAST;
				end else begin
					prev_q <= rd_q;
					cnt_q  <= cnt_q + 1'b1;
				end
			end
			ST_MUL: begin
				neg_q  <= diff_q[32];
				rem_q  <= {1'b0, prod_d[47:33]};
				qr_q   <= prod_d[32:0];
				step_q <= cplc_pkg::STEP_W'(cplc_pkg::DIV_STEPS - 1);
			end
			ST_DIV: begin
				rem_q  <= trial_ge ? trial_sub[15:0] : trial[15:0];
				qr_q   <= {qr_q[31:0], trial_ge};
				step_q <= step_q - 1'b1;
			end
			ST_FIX: begin
				res_value_q <= sat_d;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q.result_value  <= res_value_q;
			out_data_q.result_source <= res_src_q;
		end
	end

endmodule

// File: dv/tb_clamped_piecewise_linear_curve.sv
// ----------------------------------------------------------------------------
// tb_clamped_piecewise_linear_curve - self-checking bench of the curve evaluator
// Loads point tables (sorted, tightly packed with repeats, unsorted) and queries
// levels around the stored points under several register settings. A local
// curve predictor works out every answer at item acceptance; the result beats
// are checked in order. Both channels idle in short random bursts, and the
// result side once holds off long enough for the block to back up.
// ----------------------------------------------------------------------------
module tb_clamped_piecewise_linear_curve;
	import cplc_pkg::*;

	localparam int     RAND_ITEMS = 1750;
	localparam longint VAL_MAX    = 64'sd2147483647;
	localparam longint VAL_MIN    = -64'sd2147483648;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	item_t       in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	result_t     out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_ENABLE;
	logic [31:0] cfg_data  = '0;

	// items waiting for the driver, answers waiting for their result beat
	item_t   pending[$];
	result_t answers_due[$];
	result_t due;

	// predictor copy of the registers and the point table
	logic               m_enabled = 1'b0;
	logic signed [31:0] m_base    = '0;
	logic [4:0]         m_count   = '0;
	logic signed [15:0] tbl_level[MAX_POINTS];
	logic signed [31:0] tbl_value[MAX_POINTS];

	// table as the stimulus has planned it, used to aim the queries
	logic signed [15:0] plan_level[MAX_POINTS];

	logic idle_on   = 1'b1;
	logic long_hold = 1'b0;
	int   gap_left  = 0;
	int   stall_left = 0;
	int   errors    = 0;
	int   items_queued = 0;
	int   phase     = 0;

	clamped_piecewise_linear_curve dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// Curve predictor: applies a load to the table copy, or evaluates a query
	// against the registers. Returns the result beat the block must give.
	// ------------------------------------------------------------------------
	function automatic result_t curve_answer(item_t it);
		result_t r;
		int      n;
		int      k;
		longint  q, lo, hi, lv, uv, quo, sum;
		r.result_value  = '0;
		r.result_source = SRC_ACK;
		if (it.mode == MODE_LOAD) begin
			tbl_level[it.point_index] = it.point_level;
			tbl_value[it.point_index] = it.point_value;
			return r;
		end
		// a count beyond the table size means the whole table
		n = (m_count > MAX_POINTS) ? MAX_POINTS : int'(m_count);
		if (!m_enabled || n == 0) begin
			r.result_value  = m_base;
			r.result_source = SRC_BASE;
			return r;
		end
		// first slot, in slot order, whose level reaches the query level
		k = 0;
		while (k < n && tbl_level[k] < it.query_level)
			k++;
		if (k == 0) begin
			r.result_value  = tbl_value[0];
			r.result_source = SRC_FIRST;
			return r;
		end
		if (k >= n) begin
			r.result_value  = tbl_value[n - 1];
			r.result_source = SRC_LAST;
			return r;
		end
		r.result_source = SRC_INTERP;
		q  = it.query_level;
		lo = tbl_level[k - 1];
		hi = tbl_level[k];
		lv = tbl_value[k - 1];
		uv = tbl_value[k];
		if (hi <= lo) begin
			r.result_value = tbl_value[k - 1];
			return r;
		end
		// exact product, quotient truncated toward zero, saturating sum
		quo = ((uv - lv) * (q - lo)) / (hi - lo);
		sum = lv + quo;
		if (sum > VAL_MAX)
			sum = VAL_MAX;
		else if (sum < VAL_MIN)
			sum = VAL_MIN;
		r.result_value = sum[31:0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Driver: offers queued items, holds a stalled beat, predicts on accept
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				answers_due = {answers_due, curve_answer(in_data)};
			// a stalled beat stays put; otherwise pick idle or the next item
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					in_data  <= pending.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks each accepted result beat, drives the result stall
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					$display("%0t: result beat with nothing expected, value %0d source %0d",
						$time, out_data.result_value, out_data.result_source);
					errors++;
				end else begin
					due = answers_due.pop_front();
					if (out_data.result_value !== due.result_value) begin
						$display("%0t: result_value mismatch, expected %0d, actual %0d",
							$time, due.result_value, out_data.result_value);
						errors++;
					end
					if (out_data.result_source !== due.result_source) begin
						$display("%0t: result_source mismatch, expected %0d, actual %0d",
							$time, due.result_source, out_data.result_source);
						errors++;
					end
				end
			end
			if (long_hold) begin
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_load(input int slot, input logic signed [15:0] lvl,
			input logic signed [31:0] val);
		item_t it;
		it.mode        = MODE_LOAD;
		it.point_index = slot[3:0];
		it.point_level = lvl;
		it.point_value = val;
		it.query_level = 16'($urandom());  // ignored by a load, toggled anyway
		plan_level[slot] = lvl;
		pending = {pending, it};
		items_queued++;
	endtask

	task automatic queue_query(input logic signed [15:0] lvl);
		item_t it;
		it.mode        = MODE_QUERY;
		it.point_index = 4'($urandom());
		it.point_level = 16'($urandom());
		it.point_value = $urandom();
		it.query_level = lvl;
		pending = {pending, it};
		items_queued++;
	endtask

	// sender pauses until every answer is back; ends on a falling edge
	task automatic settle();
		do
			@(negedge clk);
		while (pending.size() != 0 || in_valid || answers_due.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	// register write; only called with the block idle
	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ENABLE: m_enabled = data[0];
			CFG_BASE:   m_base    = data;
			CFG_COUNT:  m_count   = data[4:0];
			default:    ;
		endcase
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3, 4:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return 32'd2;
			3, 4:    return MAX_POINTS;
			5:       return $urandom_range(MAX_POINTS + 1, 31);  // beyond the table
			default: return $urandom_range(3, MAX_POINTS - 1);
		endcase
	endfunction

	// mostly aimed at or between live points, some anywhere, some at the ends
	function automatic logic signed [15:0] pick_level();
		int n, k, sel, v, a, b;
		n   = (m_count > MAX_POINTS) ? MAX_POINTS : int'(m_count);
		sel = $urandom_range(0, 9);
		if (n == 0 || sel == 0)
			return 16'($urandom());
		if (sel == 1)
			return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
		k = $urandom_range(0, n - 1);
		if (sel < 6 || k == n - 1) begin
			v = int'(plan_level[k]) + int'($urandom_range(0, 8)) - 4;
			return v[15:0];
		end
		a = int'(plan_level[k]);
		b = int'(plan_level[k + 1]);
		if (a > b) begin
			v = a;
			a = b;
			b = v;
		end
		v = a + int'($urandom_range(0, b - a));
		return v[15:0];
	endfunction

	// whole table: wide ascending, tight ascending with repeats, or unsorted
	task automatic fill_table(input int kind);
		int lvl;
		lvl = (kind == 1) ? -32768 + int'($urandom_range(0, 65535 - 48))
			: -32768 + int'($urandom_range(0, 65535 - 16 * 4000));
		for (int k = 0; k < MAX_POINTS; k++) begin
			if (kind == 2)
				lvl = int'($signed(16'($urandom())));
			queue_load(k, lvl[15:0], pick_value());
			lvl += (kind == 1) ? int'($urandom_range(0, 3)) : int'($urandom_range(1, 4000));
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// registers as reset: curve off, base zero
		@(negedge clk);
		queue_query(16'sd0);
		settle();
		cfg_write(CFG_BASE, 32'h8000_0000);
		@(negedge clk);
		queue_query(16'sh7FFF);
		// enabled but empty: still the base value
		settle();
		cfg_write(CFG_ENABLE, 32'd1);
		@(negedge clk);
		queue_query(-16'sd1);

		// directed table: extreme ends, a repeated level, a falling segment
		queue_load(0, 16'sh8000, 32'sh8000_0000);
		queue_load(1, -16'sd100, 32'sh7FFF_FFFF);
		queue_load(2, -16'sd100, 32'sd5);
		queue_load(3, 16'sd0, -32'sd65536);
		for (int k = 4; k < MAX_POINTS - 1; k++)
			queue_load(k, 16'(1000 * k), $urandom());
		queue_load(MAX_POINTS - 1, 16'sd32000, 32'sh7FFF_FFFF);
		settle();
		cfg_write(CFG_COUNT, MAX_POINTS);
		cfg_write(CFG_BASE, 32'h7FFF_FFFF);
		@(negedge clk);
		queue_query(16'sh8000);     // on the first level
		queue_query(-16'sd32767);   // full-scale rise over a wide span
		queue_query(-16'sd100);     // lands exactly on the upper point
		queue_query(-16'sd99);      // past the repeated level, falling segment
		queue_query(-16'sd50);
		queue_query(16'sd31999);
		queue_query(16'sh7FFF);     // beyond the last level
		// single point
		settle();
		cfg_write(CFG_COUNT, 32'd1);
		@(negedge clk);
		queue_query(16'sd5);
		queue_query(16'sh8000);
		// count beyond the table size
		settle();
		cfg_write(CFG_COUNT, 32'd31);
		@(negedge clk);
		queue_query(16'sh7FFF);
		queue_query(16'sd20000);

		// random phases: new settings, sometimes a new table, then a burst
		while (items_queued < RAND_ITEMS + 40) begin
			settle();
			phase++;
			cfg_write(CFG_ENABLE, 32'($urandom_range(0, 7) != 0));
			if ($urandom_range(0, 2) == 0)
				cfg_write(CFG_BASE, pick_value());
			cfg_write(CFG_COUNT, pick_count());
			@(negedge clk);
			if (phase % 3 == 1)
				fill_table($urandom_range(0, 2));
			if (items_queued > RAND_ITEMS - 150)
				idle_on <= 1'b0;
			repeat ($urandom_range(20, 80)) begin
				if ($urandom_range(0, 9) == 0)
					queue_load($urandom_range(0, MAX_POINTS - 1), 16'($urandom()),
						pick_value());
				else
					queue_query(pick_level());
			end
			// once: results held back while items keep coming, block backs up
			if (phase == 3) begin
				long_hold <= 1'b1;
				repeat (200) @(posedge clk);
				long_hold <= 1'b0;
			end
		end

		settle();
		repeat (60) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#10000000;
		$display("FAIL");
		$finish;
	end

endmodule

// File: clamped_piecewise_linear_curve.f
hw/rtl/cplc_pkg.sv
hw/rtl/clamped_piecewise_linear_curve.sv
dv/tb_clamped_piecewise_linear_curve.sv
